### hdl/aws_pkg.sv
// ----------------------------------------------------------------------------
// aws_pkg
// Shared types and constants for the axis waypoint sequencer.
// ----------------------------------------------------------------------------
package aws_pkg;

	localparam int MAX_WAYPOINTS = 8;
	localparam int WP_AW         = $clog2(MAX_WAYPOINTS);

	localparam int POS_W  = 16;
	localparam int VEL_W  = 16;
	localparam int ACC_W  = 20;
	localparam int STAT_W = 7;
	localparam int IDX_W  = 3;
	localparam int CNT_W  = 4;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 20;

	localparam logic [CNT_W-1:0] WP_COUNT_RST = CNT_W'(5);
	localparam logic [POS_W-1:0] HOME_POS_RST = POS_W'(700);
	localparam logic [VEL_W-1:0] HOME_VEL_RST = VEL_W'(500);
	localparam logic [ACC_W-1:0] HOME_ACC_RST = ACC_W'(5000);

	// operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_WP_COUNT  = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] REG_HOME_POS  = CFG_AW'(1);
	localparam logic [CFG_AW-1:0] REG_HOME_VEL  = CFG_AW'(2);
	localparam logic [CFG_AW-1:0] REG_HOME_ACC  = CFG_AW'(3);

	// drive status bit positions
	localparam int ST_ACTIVE   = 0;
	localparam int ST_POWERED  = 1;
	localparam int ST_HOMED    = 2;
	localparam int ST_ERR      = 3;
	localparam int ST_UPD_DONE = 4;
	localparam int ST_MV_ACT   = 5;
	localparam int ST_IN_POS   = 6;

	typedef enum logic [3:0] {
		SEQ_ACTIVE = 4'd0,
		SEQ_POWER  = 4'd1,
		SEQ_HOME   = 4'd2,
		SEQ_WAIT   = 4'd3,
		SEQ_UPD    = 4'd4,
		SEQ_MOT1   = 4'd5,
		SEQ_MOT2   = 4'd6,
		SEQ_HUPD   = 4'd7,
		SEQ_HMOT1  = 4'd8,
		SEQ_HMOT2  = 4'd9,
		SEQ_STOP   = 4'd10,
		SEQ_ERROR  = 4'd11
	} seq_state_t;

	typedef struct packed {
		logic              op;
		logic [STAT_W-1:0] drive_status;
		logic              home_request;
		logic              start_request;
		logic              stop_request;
		logic [IDX_W-1:0]  wp_index;
		logic [POS_W-1:0]  wp_position;
		logic [VEL_W-1:0]  wp_velocity;
	} in_item_t;

	typedef struct packed {
		logic [3:0]       seq_state;
		logic [POS_W-1:0] target_position;
		logic [VEL_W-1:0] target_velocity;
		logic [ACC_W-1:0] target_accel;
		logic             update_cmd;
		logic             move_cmd;
		logic             drive_home_cmd;
		logic [IDX_W-1:0] waypoint_now;
	} res_item_t;

	typedef struct packed {
		logic              we;
		logic [CFG_AW-1:0] index;
		logic [CFG_DW-1:0] data;
	} cfg_wr_t;

endpackage

### hdl/aws_seq_core.sv
// ----------------------------------------------------------------------------
// aws_seq_core
// Sequencer state, request latches, waypoint table and next-state logic.
// The result is the state after the step; the state registers update when step is high.
// ----------------------------------------------------------------------------
module aws_seq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  aws_pkg::in_item_t  item,
	input  aws_pkg::cfg_wr_t   cfg,
	output aws_pkg::res_item_t result
);
	import aws_pkg::*;

	logic [CNT_W-1:0] wp_count_q;
	logic [POS_W-1:0] home_pos_q;
	logic [VEL_W-1:0] home_vel_q;
	logic [ACC_W-1:0] home_acc_q;

	seq_state_t       st_q, st_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             hl_q, hl_d, sl_q, sl_d, stl_q, stl_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [VEL_W-1:0] vel_q, vel_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic             upd_q, upd_d, mv_q, mv_d, dh_q, dh_d;

	logic [POS_W-1:0] pos_tbl_q [MAX_WAYPOINTS];
	logic [VEL_W-1:0] vel_tbl_q [MAX_WAYPOINTS];

	logic [IDX_W-1:0] last_idx;
	logic [POS_W-1:0] tbl_pos;
	logic [VEL_W-1:0] tbl_vel;
	logic             active, powered, homed, err, upd_done, mv_active, in_pos;

	assign active    = item.drive_status[ST_ACTIVE];
	assign powered   = item.drive_status[ST_POWERED];
	assign homed     = item.drive_status[ST_HOMED];
	assign err       = item.drive_status[ST_ERR];
	assign upd_done  = item.drive_status[ST_UPD_DONE];
	assign mv_active = item.drive_status[ST_MV_ACT];
	assign in_pos    = item.drive_status[ST_IN_POS];

	assign tbl_pos = pos_tbl_q[idx_q[WP_AW-1:0]];
	assign tbl_vel = vel_tbl_q[idx_q[WP_AW-1:0]];

	// count 0 acts as 1, counts past the table act as the table size
	always_comb begin
		if (wp_count_q == '0)
			last_idx = '0;
		else if (32'(wp_count_q) > MAX_WAYPOINTS)
			last_idx = IDX_W'(MAX_WAYPOINTS - 1);
		else
			last_idx = IDX_W'(wp_count_q - CNT_W'(1));
	end

	always_comb begin
		st_d  = st_q;
		idx_d = idx_q;
		hl_d  = hl_q;
		sl_d  = sl_q;
		stl_d = stl_q;
		pos_d = pos_q;
		vel_d = vel_q;
		acc_d = acc_q;
		upd_d = upd_q;
		mv_d  = mv_q;
		dh_d  = dh_q;
		if (item.op == OP_TICK) begin
			hl_d  = hl_q | item.home_request;
			sl_d  = sl_q | item.start_request;
			stl_d = stl_q | item.stop_request;
			case (st_q)
				SEQ_ACTIVE: begin
					if (active) st_d = SEQ_POWER;
				end
				SEQ_POWER: begin
					if (powered) st_d = SEQ_HOME;
				end
				SEQ_HOME: begin
					if (homed) begin
						dh_d = 1'b0;
						hl_d = 1'b0;
						st_d = SEQ_WAIT;
					end
				end
				SEQ_WAIT: begin
					// start wins over home
					if (sl_d) begin
						idx_d = '0;
						st_d  = SEQ_UPD;
					end else if (hl_d) begin
						st_d = SEQ_HUPD;
					end
				end
				SEQ_UPD: begin
					pos_d = tbl_pos;
					vel_d = tbl_vel;
					acc_d = {1'b0, tbl_vel, 3'b000} + {3'b000, tbl_vel, 1'b0};
					upd_d = 1'b1;
					if (upd_done) st_d = SEQ_MOT1;
				end
				SEQ_MOT1: begin
					mv_d = 1'b1;
					if (mv_active) st_d = SEQ_MOT2;
				end
				SEQ_MOT2: begin
					if (stl_d) begin
						st_d = SEQ_STOP;
					end else if (in_pos) begin
						mv_d = 1'b0;
						if (idx_q >= last_idx) begin
							st_d = SEQ_WAIT;
						end else begin
							idx_d = idx_q + IDX_W'(1);
							st_d  = SEQ_UPD;
						end
					end
				end
				SEQ_HUPD: begin
					pos_d = home_pos_q;
					vel_d = home_vel_q;
					acc_d = home_acc_q;
					upd_d = 1'b1;
					if (upd_done) st_d = SEQ_HMOT1;
				end
				SEQ_HMOT1: begin
					mv_d = 1'b1;
					if (mv_active) st_d = SEQ_HMOT2;
				end
				SEQ_HMOT2: begin
					if (in_pos) begin
						mv_d = 1'b0;
						hl_d = 1'b0;
						st_d = SEQ_WAIT;
					end
				end
				SEQ_STOP: begin
					stl_d = 1'b0;
					sl_d  = 1'b0;
					mv_d  = 1'b0;
					if (!mv_active) st_d = SEQ_WAIT;
				end
				SEQ_ERROR: begin
					hl_d  = 1'b0;
					upd_d = 1'b0;
					stl_d = 1'b0;
					sl_d  = 1'b0;
					mv_d  = 1'b0;
					if (!err) st_d = SEQ_WAIT;
				end
				default: begin
					st_d = st_q;
				end
			endcase
			if (hl_d && !homed) dh_d = 1'b1;
			if (err) st_d = SEQ_ERROR;
		end
	end

	always_comb begin
		result.seq_state       = st_d;
		result.target_position = pos_d;
		result.target_velocity = vel_d;
		result.target_accel    = acc_d;
		result.update_cmd      = upd_d;
		result.move_cmd        = mv_d;
		result.drive_home_cmd  = dh_d;
		result.waypoint_now    = idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_count_q <= WP_COUNT_RST;
			home_pos_q <= HOME_POS_RST;
			home_vel_q <= HOME_VEL_RST;
			home_acc_q <= HOME_ACC_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_WP_COUNT: wp_count_q <= cfg.data[CNT_W-1:0];
				REG_HOME_POS: home_pos_q <= cfg.data[POS_W-1:0];
				REG_HOME_VEL: home_vel_q <= cfg.data[VEL_W-1:0];
				REG_HOME_ACC: home_acc_q <= cfg.data[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= SEQ_ACTIVE;
			idx_q <= '0;
			hl_q  <= 1'b0;
			sl_q  <= 1'b0;
			stl_q <= 1'b0;
			pos_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
			upd_q <= 1'b0;
			mv_q  <= 1'b0;
			dh_q  <= 1'b0;
		end else if (step) begin
			st_q  <= st_d;
			idx_q <= idx_d;
			hl_q  <= hl_d;
			sl_q  <= sl_d;
			stl_q <= stl_d;
			pos_q <= pos_d;
			vel_q <= vel_d;
			acc_q <= acc_d;
			upd_q <= upd_d;
			mv_q  <= mv_d;
			dh_q  <= dh_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item.op == OP_LOAD && 32'(item.wp_index) < MAX_WAYPOINTS) begin
			pos_tbl_q[item.wp_index[WP_AW-1:0]] <= item.wp_position;
			vel_tbl_q[item.wp_index[WP_AW-1:0]] <= item.wp_velocity;
		end
	end

endmodule

### hdl/axis_waypoint_sequencer_top.sv
// ----------------------------------------------------------------------------
// axis_waypoint_sequencer_top
// Single-axis motion sequencer: input register, sequencer core, result register.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   op, drive_status, requests, waypoint entry
//   out      out_valid / out_stall seq_state, targets, commands, waypoint_now
//   cfg      cfg_we                cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; an accepted beat passes the
// input register, then the sequencer step into the result register.
// The sequencer state updates in the same cycle the result register loads.
// A stalled result holds both stages; in_stall rises once the input register
// is full and cannot move on. Reset clears control state and sets config defaults.
// ----------------------------------------------------------------------------
module axis_waypoint_sequencer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [aws_pkg::STAT_W-1:0]     drive_status,
	input  logic                           home_request,
	input  logic                           start_request,
	input  logic                           stop_request,
	input  logic [aws_pkg::IDX_W-1:0]      wp_index,
	input  logic [aws_pkg::POS_W-1:0]      wp_position,
	input  logic [aws_pkg::VEL_W-1:0]      wp_velocity,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     seq_state,
	output logic [aws_pkg::POS_W-1:0]      target_position,
	output logic [aws_pkg::VEL_W-1:0]      target_velocity,
	output logic [aws_pkg::ACC_W-1:0]      target_accel,
	output logic                           update_cmd,
	output logic                           move_cmd,
	output logic                           drive_home_cmd,
	output logic [aws_pkg::IDX_W-1:0]      waypoint_now,
	input  logic                           cfg_we,
	input  logic [aws_pkg::CFG_AW-1:0]     cfg_index,
	input  logic [aws_pkg::CFG_DW-1:0]     cfg_data
);
	import aws_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	res_item_t res_d, res_q;
	logic      out_valid_q;
	logic      advance;
	logic      in_take;
	cfg_wr_t   cfg;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op            <= op;
			item_s1.drive_status  <= drive_status;
			item_s1.home_request  <= home_request;
			item_s1.start_request <= start_request;
			item_s1.stop_request  <= stop_request;
			item_s1.wp_index      <= wp_index;
			item_s1.wp_position   <= wp_position;
			item_s1.wp_velocity   <= wp_velocity;
		end
		if (advance)
			res_q <= res_d;
	end

	aws_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	assign out_valid       = out_valid_q;
	assign seq_state       = res_q.seq_state;
	assign target_position = res_q.target_position;
	assign target_velocity = res_q.target_velocity;
	assign target_accel    = res_q.target_accel;
	assign update_cmd      = res_q.update_cmd;
	assign move_cmd        = res_q.move_cmd;
	assign drive_home_cmd  = res_q.drive_home_cmd;
	assign waypoint_now    = res_q.waypoint_now;

endmodule

### hdl/aws_checker.sv
// ----------------------------------------------------------------------------
// aws_checker
// Port-level checks for the axis waypoint sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module aws_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [3:0]                 seq_state,
	input logic [aws_pkg::POS_W-1:0]  target_position,
	input logic [aws_pkg::VEL_W-1:0]  target_velocity,
	input logic                       update_cmd,
	input logic                       move_cmd
);
	import aws_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(seq_state)
			&& $stable(target_position) && $stable(move_cmd))
		else $error("result beat changed while stalled");

	// an accepted beat reaches the output once the output side is free
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted beat produced no result");

	// move command is only up during a move, or on entry to stop or error
	// before those states clear it
	a_move_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_cmd |-> seq_state == SEQ_MOT1 || seq_state == SEQ_MOT2
			|| seq_state == SEQ_HMOT1 || seq_state == SEQ_HMOT2
			|| seq_state == SEQ_STOP || seq_state == SEQ_ERROR)
		else $error("move command outside a move");

	// before power-up nothing has been commanded
	a_startup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (seq_state == SEQ_ACTIVE || seq_state == SEQ_POWER)
			|-> !update_cmd && !move_cmd && target_velocity == '0)
		else $error("command issued before power-up");

endmodule

bind axis_waypoint_sequencer_top aws_checker u_aws_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.seq_state       (seq_state),
	.target_position (target_position),
	.target_velocity (target_velocity),
	.update_cmd      (update_cmd),
	.move_cmd        (move_cmd)
);
